@@ hdl/can_tx_pkg.sv @@
package can_tx_pkg;

    localparam int MAILBOXES = 3;
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int MBOX_W    = 2;
    localparam int IDENT_W   = 11;
    localparam int DATA_W    = 64;

    localparam int IN_BITS  = SLOT_W + IDENT_W + DATA_W + MAILBOXES;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + MBOX_W + 1 + IDENT_W + DATA_W + SLOT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ACT_POST    = 2'd0,
        ACT_SERVICE = 2'd1,
        ACT_FLUSH   = 2'd2
    } action_t;

    typedef struct packed {
        logic                issued;
        logic [MBOX_W-1:0]   mailbox;
        logic                load_ident;
        logic [IDENT_W-1:0]  tx_ident;
        logic [DATA_W-1:0]   tx_payload;
        logic [SLOT_W-1:0]   from_slot;
        logic                blocked;
    } result_t;

endpackage

@@ hdl/can_tx_mailbox_scheduler.sv @@
// CAN transmit mailbox scheduler. Each input beat is a post (store an 11-bit
// identifier and 8 data bytes in a transmit slot and mark it waiting), a
// service attempt (take the lowest waiting slot and hand it to one of three
// hardware mailboxes), or a flush (drop every waiting slot; mailbox bindings
// stay). A mailbox already bound to the message identifier is used only when
// its mailbox_empty bit is set, otherwise the slot keeps waiting and blocked
// is raised; with no such binding the first unbound mailbox is bound, else
// the first empty one is rebound, and load_ident asks software to reprogram
// the mailbox identifier and length 8. Every input beat yields exactly one
// result beat; non-service beats and idle services yield an all-zero result.
// Throughput is one beat per clock while the output is not stalled by
// m_tready: the slot priority encoder and the three identifier compares sit
// in one stage between the input register and the result register, so each
// beat is captured in the input register and its result then in the result
// register, and the next beat always sees the state left by the previous one.
// Posts to a slot index at or above SLOTS are ignored; since the slot field
// is 4 bits, at most 16 slots are ever stored.
module can_tx_mailbox_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] slot, [14:4] ident, [78:15] payload, [81:79] mailbox_empty
    input  logic [can_tx_pkg::IN_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] issued, [2:1] mailbox, [3] load_ident, [14:4] tx_ident,
    // [78:15] tx_payload, [82:79] from_slot, [83] blocked
    output logic [can_tx_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_CNT = (SLOTS < can_tx_pkg::MAX_SLOTS) ? SLOTS
                                                                : can_tx_pkg::MAX_SLOTS;
    localparam int SW = can_tx_pkg::SLOT_W;
    localparam int IW = can_tx_pkg::IDENT_W;
    localparam int DW = can_tx_pkg::DATA_W;
    localparam int MB = can_tx_pkg::MAILBOXES;
    localparam int MW = can_tx_pkg::MBOX_W;

    // input stage
    logic                  s1_valid_reg;
    can_tx_pkg::action_t   s1_action_reg;
    logic [SW-1:0]         s1_slot_reg;
    logic [IW-1:0]         s1_ident_reg;
    logic [DW-1:0]         s1_payload_reg;
    logic [MB-1:0]         s1_empty_reg;

    // result stage
    logic                  out_valid_reg;
    can_tx_pkg::result_t   out_res_reg;

    // scheduler state
    logic [SLOT_CNT-1:0]   waiting_reg, waiting_next;
    logic [IW-1:0]         slot_ident_reg [SLOT_CNT];
    logic [DW-1:0]         slot_data_reg  [SLOT_CNT];
    logic [MB-1:0]         bound_reg, bound_next;
    logic [IW-1:0]         mb_ident_reg [MB];

    logic                  advance;
    logic                  s1_fire;
    logic                  in_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    // lowest waiting slot
    logic          found;
    logic [SW-1:0] sel_slot;
    logic [IW-1:0] sel_ident;
    logic [DW-1:0] sel_data;

    always_comb
    begin
        found    = 1'b0;
        sel_slot = '0;
        for (int k = SLOT_CNT - 1; k >= 0; k--)
        begin
            if (waiting_reg[k])
            begin
                found    = 1'b1;
                sel_slot = SW'(k);
            end
        end
    end

    always_comb
    begin
        sel_ident = '0;
        sel_data  = '0;
        for (int k = 0; k < SLOT_CNT; k++)
        begin
            if (sel_slot == SW'(k))
            begin
                sel_ident = slot_ident_reg[k];
                sel_data  = slot_data_reg[k];
            end
        end
    end

    // mailbox choice: identifier match, else first unbound, else first empty
    logic          hit, unbound_any, empty_any;
    logic [MW-1:0] hit_idx, unbound_idx, empty_idx;

    always_comb
    begin
        hit         = 1'b0;
        unbound_any = 1'b0;
        empty_any   = 1'b0;
        hit_idx     = '0;
        unbound_idx = '0;
        empty_idx   = '0;
        for (int k = MB - 1; k >= 0; k--)
        begin
            if (bound_reg[k] && (mb_ident_reg[k] == sel_ident))
            begin
                hit     = 1'b1;
                hit_idx = MW'(k);
            end
            if (!bound_reg[k])
            begin
                unbound_any = 1'b1;
                unbound_idx = MW'(k);
            end
            if (s1_empty_reg[k])
            begin
                empty_any = 1'b1;
                empty_idx = MW'(k);
            end
        end
    end

    logic          use_ok;
    logic [MW-1:0] use_idx;
    logic          load;

    always_comb
    begin
        use_ok  = 1'b0;
        use_idx = '0;
        load    = 1'b0;
        if (hit)
        begin
            use_ok  = s1_empty_reg[hit_idx];
            use_idx = hit_idx;
        end
        else if (unbound_any)
        begin
            use_ok  = 1'b1;
            use_idx = unbound_idx;
            load    = 1'b1;
        end
        else if (empty_any)
        begin
            use_ok  = 1'b1;
            use_idx = empty_idx;
            load    = 1'b1;
        end
    end

    // result and next state for the beat in the input stage
    can_tx_pkg::result_t res;
    logic                do_post;
    logic                do_bind;

    always_comb
    begin
        res          = '0;
        waiting_next = waiting_reg;
        bound_next   = bound_reg;
        do_post      = 1'b0;
        do_bind      = 1'b0;
        case (s1_action_reg)
            can_tx_pkg::ACT_POST:
            begin
                for (int k = 0; k < SLOT_CNT; k++)
                begin
                    if (s1_slot_reg == SW'(k))
                    begin
                        waiting_next[k] = 1'b1;
                        do_post         = 1'b1;
                    end
                end
            end
            can_tx_pkg::ACT_SERVICE:
            begin
                if (found)
                begin
                    if (use_ok)
                    begin
                        res.issued     = 1'b1;
                        res.mailbox    = use_idx;
                        res.load_ident = load;
                        res.tx_ident   = sel_ident;
                        res.tx_payload = sel_data;
                        res.from_slot  = sel_slot;
                        for (int k = 0; k < SLOT_CNT; k++)
                        begin
                            if (sel_slot == SW'(k))
                            begin
                                waiting_next[k] = 1'b0;
                            end
                        end
                        if (load)
                        begin
                            bound_next[use_idx] = 1'b1;
                            do_bind             = 1'b1;
                        end
                    end
                    else
                    begin
                        res.blocked = 1'b1;
                    end
                end
            end
            can_tx_pkg::ACT_FLUSH:
            begin
                waiting_next = '0;
            end
            default:
            begin
                // unused code: no state change, all-zero result
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            waiting_reg   <= '0;
            bound_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                waiting_reg <= waiting_next;
                bound_reg   <= bound_next;
            end
        end
    end

    // payload registers and storage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg  <= can_tx_pkg::action_t'(s_tuser);
            s1_slot_reg    <= s_tdata[3:0];
            s1_ident_reg   <= s_tdata[14:4];
            s1_payload_reg <= s_tdata[78:15];
            s1_empty_reg   <= s_tdata[81:79];
        end
        if (s1_fire)
        begin
            out_res_reg <= res;
            if (do_post)
            begin
                for (int k = 0; k < SLOT_CNT; k++)
                begin
                    if (s1_slot_reg == SW'(k))
                    begin
                        slot_ident_reg[k] <= s1_ident_reg;
                        slot_data_reg[k]  <= s1_payload_reg;
                    end
                end
            end
            if (do_bind)
            begin
                for (int k = 0; k < MB; k++)
                begin
                    if (use_idx == MW'(k))
                    begin
                        mb_ident_reg[k] <= sel_ident;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(can_tx_pkg::OUT_TDATA_W - can_tx_pkg::OUT_BITS){1'b0}},
                       out_res_reg.blocked,
                       out_res_reg.from_slot,
                       out_res_reg.tx_payload,
                       out_res_reg.tx_ident,
                       out_res_reg.load_ident,
                       out_res_reg.mailbox,
                       out_res_reg.issued};

    // checks
    a_issue_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res.issued |=>
            $countones(waiting_reg) == $countones($past(waiting_reg)) - 1)
        else $error("issued slot not retired");

    a_load_binds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res.load_ident |=> bound_reg[$past(res.mailbox)])
        else $error("reloaded mailbox left unbound");

    a_bound_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(bound_reg) != '0 |-> (bound_reg & $past(bound_reg)) == $past(bound_reg))
        else $error("mailbox binding lost");

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_action_reg != can_tx_pkg::ACT_SERVICE |-> res == '0)
        else $error("non-service beat gave a result");

    a_issue_xor_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.issued && out_res_reg.blocked))
        else $error("result both issued and blocked");

endmodule
